// File: sv/cft_pkg.sv
`default_nettype none

package cft_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int OUT_COL_W   = 5;
    localparam int RESULT_CAP  = 32;
    localparam int LEN_SAT     = 5;
    localparam int TOKEN_COUNT = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;

    // Null tokens: empty, \N, NA, nan, None, NULL.
    localparam logic [7:0] TOK_TEXT [TOKEN_COUNT][4] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5C, 8'h4E, 8'h00, 8'h00},
        '{8'h4E, 8'h41, 8'h00, 8'h00},
        '{8'h6E, 8'h61, 8'h6E, 8'h00},
        '{8'h4E, 8'h6F, 8'h6E, 8'h65},
        '{8'h4E, 8'h55, 8'h4C, 8'h4C}
    };
    localparam logic [2:0] TOK_LEN [TOKEN_COUNT] = '{3'd0, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4};

    typedef enum logic {
        KIND_CONTENT   = 1'b0,
        KIND_FIELD_END = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       field_byte;
        logic [COL_W-1:0] column;
        logic             field_null;
        logic             header_row;
        logic             row_end;
        logic             pad;
        logic [COL_W-1:0] pad_last;
        logic [COL_W-1:0] limit;
    } t_cmd;

    typedef struct packed {
        logic header_seen;
        logic quoting;
        logic row_nonempty;
    } t_front_stat;

endpackage

`default_nettype wire

// File: sv/cft_in_if.sv
`default_nettype none

interface cft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       flush;

    modport source (output valid, data_byte, flush, input ready);
    modport sink (input valid, data_byte, flush, output ready);
endinterface

`default_nettype wire

// File: sv/cft_out_if.sv
`default_nettype none

interface cft_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [7:0]                     field_byte;
    logic [cft_pkg::OUT_COL_W-1:0]  column;
    logic                           field_null;
    logic                           header_row;
    logic                           row_end;
    logic                           last_of_run;

    modport source (output valid, kind, field_byte, column, field_null, header_row, row_end,
                    last_of_run, input ready);
    modport sink (input valid, kind, field_byte, column, field_null, header_row, row_end,
                  last_of_run, output ready);
endinterface

`default_nettype wire

// File: sv/csv_field_tokenizer_top.sv
`default_nettype none

// Channel   Direction  Words
// i_in      in         one file byte or a flush marker
// o_out     out        one content byte or one field end
//
// The front end takes one byte every cycle while the command queue is not full.
// A byte that closes a data row with missing columns causes one word per missing
// field; the output stage sends one word a cycle while o_out is ready, and once the
// four-entry command queue has filled behind that row i_in stalls.
// Reset is synchronous and active low; no clearing pass is needed.
// i_in stalls only while the command queue is full; o_out may stall at any time.
module csv_field_tokenizer_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cft_in_if.sink    i_in,
    cft_out_if.source o_out
);

    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    cft_pkg::t_cmd         cmd;
    cft_pkg::t_cmd         head;
    cft_pkg::t_front_stat  stat;

    cft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd),
        .o_stat  (stat)
    );

    cft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    cft_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_content_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == cft_pkg::KIND_CONTENT))
        |-> (o_out.last_of_run && !o_out.row_end && !o_out.field_null))
        else $error("content word must be a single result without field-end flags");

    a_end_no_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == cft_pkg::KIND_FIELD_END)) |-> (o_out.field_byte == 8'h00))
        else $error("field end word carries a byte");

    a_header_row_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.header_row && o_out.row_end) |-> o_out.last_of_run)
        else $error("header row end is not the last word of its run");

    a_flush_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.flush)
        |=> (!stat.header_seen && !stat.quoting && !stat.row_nonempty))
        else $error("flush did not return the parser to its initial state");

endmodule

`default_nettype wire

// File: sv/cft_front.sv
`default_nettype none

module cft_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    cft_in_if.sink                    i_in,
    input  wire logic                 i_full,
    output logic                      o_push,
    output cft_pkg::t_cmd             o_cmd,
    output cft_pkg::t_front_stat      o_stat
);

    localparam int COL_W = cft_pkg::COL_W;

    logic                         r_quoting, n_quoting;
    logic                         r_quote_pending, n_quote_pending;
    logic                         r_row_nonempty, n_row_nonempty;
    logic                         r_header_seen, n_header_seen;
    logic [COL_W-1:0]             r_header_columns, n_header_columns;
    logic [COL_W-1:0]             r_current_column, n_current_column;
    logic [2:0]                   r_field_length, n_field_length;
    logic [cft_pkg::TOKEN_COUNT-1:0] r_null_match, n_null_match;

    logic                         accept;
    logic [COL_W-1:0]             lim;
    logic [COL_W-1:0]             c;
    logic [COL_W-1:0]             remaining;
    logic [COL_W-1:0]             pad_last;
    logic                         col_ok;
    logic                         last_col;
    logic                         is_null;
    logic [cft_pkg::TOKEN_COUNT-1:0] content_match;
    logic [2:0]                   len_inc;
    logic                         q;
    logic                         do_content;
    logic                         do_comma;
    logic                         do_end_row;
    logic [7:0]                   b;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;

    assign o_stat.header_seen  = r_header_seen;
    assign o_stat.quoting      = r_quoting;
    assign o_stat.row_nonempty = r_row_nonempty;

    always_comb begin
        lim      = r_header_seen ? r_header_columns : COL_W'(cft_pkg::MAX_COLUMNS);
        c        = r_current_column;
        col_ok   = c < lim;
        last_col = ({1'b0, c} + {{COL_W{1'b0}}, 1'b1}) == {1'b0, lim};
        remaining = lim - c;
        if (col_ok && (int'(remaining) > cft_pkg::RESULT_CAP)) begin
            pad_last = c + COL_W'(cft_pkg::RESULT_CAP - 1);
        end else begin
            pad_last = lim - {{(COL_W-1){1'b0}}, 1'b1};
        end
        is_null = 1'b0;
        content_match = r_null_match;
        for (int i = 0; i < cft_pkg::TOKEN_COUNT; i++) begin
            if (r_null_match[i] && (cft_pkg::TOK_LEN[i] == r_field_length)) begin
                is_null = 1'b1;
            end
            if ((r_field_length >= cft_pkg::TOK_LEN[i]) ||
                (cft_pkg::TOK_TEXT[i][r_field_length[1:0]] != b)) begin
                content_match[i] = 1'b0;
            end
        end
        len_inc = (r_field_length < 3'(cft_pkg::LEN_SAT)) ? r_field_length + 3'd1
                                                           : r_field_length;
    end

    always_comb begin
        n_quoting        = r_quoting;
        n_quote_pending  = r_quote_pending;
        n_row_nonempty   = r_row_nonempty;
        n_header_seen    = r_header_seen;
        n_header_columns = r_header_columns;
        n_current_column = r_current_column;
        n_field_length   = r_field_length;
        n_null_match     = r_null_match;
        do_content = 1'b0;
        do_comma   = 1'b0;
        do_end_row = 1'b0;
        q          = r_quoting;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.header_row = !r_header_seen;
        o_cmd.limit      = lim;
        o_cmd.column     = c;
        o_cmd.pad_last   = pad_last;

        if (accept) begin
            if (i_in.flush) begin
                do_end_row = r_row_nonempty;
            end else if (b == cft_pkg::CHAR_NEWLINE) begin
                do_end_row = r_row_nonempty || !r_header_seen;
            end else begin
                n_row_nonempty = 1'b1;
                if (r_quote_pending && (b == cft_pkg::CHAR_QUOTE)) begin
                    n_quote_pending = 1'b0;
                    do_content      = 1'b1;
                end else begin
                    if (r_quote_pending) begin
                        n_quote_pending = 1'b0;
                        n_quoting       = 1'b0;
                        q               = 1'b0;
                    end
                    if (b == cft_pkg::CHAR_QUOTE) begin
                        if (q) begin
                            n_quote_pending = 1'b1;
                        end else begin
                            n_quoting = 1'b1;
                        end
                    end else if ((b == cft_pkg::CHAR_COMMA) && !q) begin
                        do_comma = 1'b1;
                    end else begin
                        do_content = 1'b1;
                    end
                end
            end
        end

        if (do_content) begin
            o_push           = col_ok;
            o_cmd.kind       = cft_pkg::KIND_CONTENT;
            o_cmd.field_byte = b;
            n_null_match     = content_match;
            n_field_length   = len_inc;
        end

        if (do_comma) begin
            o_push           = col_ok;
            o_cmd.kind       = cft_pkg::KIND_FIELD_END;
            o_cmd.field_null = is_null;
            o_cmd.row_end    = last_col;
            if (col_ok) begin
                n_current_column = c + {{(COL_W-1){1'b0}}, 1'b1};
            end
            n_field_length = '0;
            n_null_match   = '1;
        end

        if (do_end_row) begin
            o_push           = col_ok;
            o_cmd.kind       = cft_pkg::KIND_FIELD_END;
            o_cmd.field_null = is_null;
            if (!r_header_seen) begin
                o_cmd.row_end    = 1'b1;
                n_header_columns = col_ok ? c + {{(COL_W-1){1'b0}}, 1'b1} : lim;
                n_header_seen    = 1'b1;
            end else begin
                o_cmd.row_end = last_col;
                o_cmd.pad     = c < pad_last;
            end
            n_quoting        = 1'b0;
            n_quote_pending  = 1'b0;
            n_row_nonempty   = 1'b0;
            n_current_column = '0;
            n_field_length   = '0;
            n_null_match     = '1;
        end

        if (accept && i_in.flush) begin
            n_quoting        = 1'b0;
            n_quote_pending  = 1'b0;
            n_row_nonempty   = 1'b0;
            n_header_seen    = 1'b0;
            n_header_columns = '0;
            n_current_column = '0;
            n_field_length   = '0;
            n_null_match     = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoting        <= 1'b0;
            r_quote_pending  <= 1'b0;
            r_row_nonempty   <= 1'b0;
            r_header_seen    <= 1'b0;
            r_header_columns <= '0;
            r_current_column <= '0;
            r_field_length   <= '0;
            r_null_match     <= '1;
        end else begin
            r_quoting        <= n_quoting;
            r_quote_pending  <= n_quote_pending;
            r_row_nonempty   <= n_row_nonempty;
            r_header_seen    <= n_header_seen;
            r_header_columns <= n_header_columns;
            r_current_column <= n_current_column;
            r_field_length   <= n_field_length;
            r_null_match     <= n_null_match;
        end
    end

endmodule

`default_nettype wire

// File: sv/cft_queue.sv
`default_nettype none

module cft_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cft_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output cft_pkg::t_cmd       o_head
);

    localparam int QPTR_W = cft_pkg::QPTR_W;
    localparam int QCNT_W = cft_pkg::QCNT_W;

    cft_pkg::t_cmd    r_mem [cft_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = r_count == QCNT_W'(cft_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + {{(QPTR_W-1){1'b0}}, 1'b1} : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + {{(QPTR_W-1){1'b0}}, 1'b1} : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + {{(QCNT_W-1){1'b0}}, 1'b1};
        end else if (!i_push && i_pop) begin
            n_count = r_count - {{(QCNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: sv/cft_back.sv
`default_nettype none

module cft_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire cft_pkg::t_cmd  i_head,
    output logic                o_pop,
    cft_out_if.source           o_out
);

    localparam int COL_W     = cft_pkg::COL_W;
    localparam int OUT_COL_W = cft_pkg::OUT_COL_W;

    logic                 r_valid, n_valid;
    logic                 r_busy, n_busy;
    logic [COL_W-1:0]     r_col, n_col;
    logic                 r_kind;
    logic [7:0]           r_field_byte;
    logic [OUT_COL_W-1:0] r_column;
    logic                 r_field_null;
    logic                 r_header_row;
    logic                 r_row_end;
    logic                 r_last;

    logic                 load;
    logic                 produce;
    logic [COL_W-1:0]     cur_col;
    logic                 res_kind;
    logic [7:0]           res_byte;
    logic                 res_null;
    logic                 res_row_end;
    logic                 res_last;

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.field_byte  = r_field_byte;
    assign o_out.column      = r_column;
    assign o_out.field_null  = r_field_null;
    assign o_out.header_row  = r_header_row;
    assign o_out.row_end     = r_row_end;
    assign o_out.last_of_run = r_last;

    always_comb begin
        load    = !r_valid || o_out.ready;
        produce = load && !i_empty;
        cur_col = r_busy ? r_col : i_head.column;
        if (r_busy) begin
            res_kind    = cft_pkg::KIND_FIELD_END;
            res_byte    = '0;
            res_null    = 1'b1;
            res_row_end = ({1'b0, r_col} + {{COL_W{1'b0}}, 1'b1}) == {1'b0, i_head.limit};
            res_last    = r_col == i_head.pad_last;
        end else begin
            res_kind    = i_head.kind;
            res_byte    = i_head.field_byte;
            res_null    = i_head.field_null;
            res_row_end = i_head.row_end;
            res_last    = !i_head.pad;
        end
        o_pop   = produce && res_last;
        n_valid = load ? produce : r_valid;
        n_busy  = r_busy;
        n_col   = r_col;
        if (produce) begin
            n_busy = !res_last;
            n_col  = cur_col + {{(COL_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_col   <= '0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_kind       <= res_kind;
            r_field_byte <= res_byte;
            r_column     <= cur_col[OUT_COL_W-1:0];
            r_field_null <= res_null;
            r_header_row <= i_head.header_row;
            r_row_end    <= res_row_end;
            r_last       <= res_last;
        end
    end

endmodule

`default_nettype wire
